>>> rtl/core/tcca_pkg.sv
// ----------------------------------------------------------------------------
// Track cluster chi accumulator package
// Shared payload types and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tcca_pkg;

  localparam logic [15:0] ResolutionReset = 16'd9830;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoAssoc = 2'd1;
  localparam logic [1:0] StatusError   = 2'd2;

  typedef struct packed {
    logic [23:0] cluster_hadronic_energy;
    logic [23:0] cluster_comparison_energy;
    logic [7:0]  track_count;
    logic [23:0] track_energy_sum;
    logic        last_cluster;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [39:0] chi_total;
    logic [47:0]        chi_squared_total;
    logic signed [39:0] chi_mean;
    logic [47:0]        chi_squared_mean;
    logic [31:0]        unassociated_energy;
    logic [23:0]        min_associated_energy;
    logic [15:0]        excess_tracks;
  } out_item_t;

  // Classified work handed from the front part to the back part.
  typedef struct packed {
    logic        do_chi;
    logic        neg;
    logic [23:0] mag;
    logic [23:0] trk;
    logic        last;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/tcca_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one cluster per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcca_in_if;
  logic valid;
  logic ready;
  logic [23:0] cluster_hadronic_energy;
  logic [23:0] cluster_comparison_energy;
  logic [7:0]  track_count;
  logic [23:0] track_energy_sum;
  logic        last_cluster;
  modport source (output valid, cluster_hadronic_energy, cluster_comparison_energy,
                  track_count, track_energy_sum, last_cluster, input ready);
  modport sink (input valid, cluster_hadronic_energy, cluster_comparison_energy,
                track_count, track_energy_sum, last_cluster, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcca_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcca_out_if;
  logic valid;
  logic ready;
  logic [1:0]         status;
  logic signed [39:0] chi_total;
  logic [47:0]        chi_squared_total;
  logic signed [39:0] chi_mean;
  logic [47:0]        chi_squared_mean;
  logic [31:0]        unassociated_energy;
  logic [23:0]        min_associated_energy;
  logic [15:0]        excess_tracks;
  modport source (output valid, status, chi_total, chi_squared_total, chi_mean,
                  chi_squared_mean, unassociated_energy, min_associated_energy,
                  excess_tracks, input ready);
  modport sink (input valid, status, chi_total, chi_squared_total, chi_mean,
                chi_squared_mean, unassociated_energy, min_associated_energy,
                excess_tracks, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcca_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready channel carrying the resolution register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcca_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tcca_front.sv
// ----------------------------------------------------------------------------
// Front part
// Accepts clusters, updates the simple sums and queues a job for every cluster.
// ----------------------------------------------------------------------------
`default_nettype none

module tcca_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tcca_pkg::in_item_t item_i,
  input  wire logic             item_valid_i,
  output logic                  item_ready_o,
  input  wire logic [15:0]      resolution_i,
  output tcca_pkg::job_t        job_o,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output logic [31:0]           unassoc_o,
  output logic [23:0]           min_o,
  output logic [15:0]           excess_o,
  output logic                  error_o,
  input  wire logic             clear_i
);

  logic [31:0] unassoc_q, unassoc_d;
  logic [23:0] min_q, min_d;
  logic [15:0] excess_q, excess_d;
  logic        error_q, error_d;
  logic        hold_q, hold_d;
  logic        fire;
  logic [32:0] usum;
  logic [16:0] esum;
  logic        assoc;

  // After a last cluster the sums belong to the pending result until it is taken.
  assign item_ready_o = job_ready_i && !hold_q;
  assign fire         = item_valid_i && item_ready_o;
  assign assoc        = item_i.track_count != 8'd0;
  assign usum = {1'b0, unassoc_q} + {9'd0, item_i.cluster_hadronic_energy};
  assign esum = {1'b0, excess_q} + {9'd0, item_i.track_count - 8'd1};

  always_comb begin
    job_o.do_chi = assoc && item_i.track_energy_sum != 24'd0 && resolution_i != 16'd0;
    job_o.neg    = item_i.cluster_comparison_energy < item_i.track_energy_sum;
    job_o.mag    = job_o.neg ? item_i.track_energy_sum - item_i.cluster_comparison_energy
                             : item_i.cluster_comparison_energy - item_i.track_energy_sum;
    job_o.trk    = item_i.track_energy_sum;
    job_o.last   = item_i.last_cluster;
  end
  assign job_valid_o = item_valid_i && !hold_q;

  always_comb begin
    unassoc_d = clear_i ? 32'd0 : unassoc_q;
    min_d     = clear_i ? 24'hFFFFFF : min_q;
    excess_d  = clear_i ? 16'd0 : excess_q;
    error_d   = clear_i ? 1'b0 : error_q;
    hold_d    = clear_i ? 1'b0 : hold_q;
    if (fire) begin
      if (item_i.last_cluster) hold_d = 1'b1;
      if (!assoc) begin
        unassoc_d = usum[32] ? 32'hFFFFFFFF : usum[31:0];
      end else begin
        if (item_i.cluster_hadronic_energy < min_q) min_d = item_i.cluster_hadronic_energy;
        excess_d = esum[16] ? 16'hFFFF : esum[15:0];
        if (!job_o.do_chi) error_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unassoc_q <= 32'd0;
      min_q     <= 24'hFFFFFF;
      excess_q  <= 16'd0;
      error_q   <= 1'b0;
      hold_q    <= 1'b0;
    end else begin
      unassoc_q <= unassoc_d;
      min_q     <= min_d;
      excess_q  <= excess_d;
      error_q   <= error_d;
      hold_q    <= hold_d;
    end
  end

  assign unassoc_o = unassoc_q;
  assign min_o     = min_q;
  assign excess_o  = excess_q;
  assign error_o   = error_q;

endmodule

`default_nettype wire

>>> rtl/core/tcca_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue between front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tcca_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tcca_pkg::job_t push_data_i,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  output tcca_pkg::job_t      pop_data_o,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i
);

  tcca_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop_ready_i) |=> cnt_q == 2'd2) else $error("full queue lost entry");

endmodule

`default_nettype wire

>>> rtl/core/tcca_back.sv
// ----------------------------------------------------------------------------
// Back part
// Iterative square root and division for chi, accumulation and result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcca_back #(
  parameter int unsigned CountCap = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tcca_pkg::job_t  job_i,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  input  wire logic [15:0]     resolution_i,
  input  wire logic [31:0]     unassoc_i,
  input  wire logic [23:0]     min_i,
  input  wire logic [15:0]     excess_i,
  input  wire logic            error_i,
  output logic                 clear_o,
  output tcca_pkg::out_item_t  res_o,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i
);

  typedef enum logic [7:0] {
    StIdle = 8'b00000001, StSqrt = 8'b00000010, StMul = 8'b00000100,
    StDiv = 8'b00001000, StSq = 8'b00010000, StAcc = 8'b00100000,
    StMean = 8'b01000000, StOut = 8'b10000000
  } state_e;

  localparam logic [10:0] Cap = (CountCap < 2047) ? 11'(CountCap) : 11'd2047;

  state_e      state_q, state_d;
  logic [5:0]  step_q;
  tcca_pkg::job_t job_q;
  // sqrt
  logic [39:0] rem_q;
  logic [19:0] root_q;
  logic [39:0] rad_q;
  // division
  logic [57:0] num_q;
  logic [35:0] den_q;
  logic [57:0] drem_q;
  logic [57:0] quot_q;
  logic [63:0] prod_q;
  // accumulators
  logic signed [39:0] chi_q, chi_d;
  logic [47:0]        sq_q, sq_d;
  logic [10:0]        cnt_q, cnt_d;
  // means
  logic [47:0] mnum_q, mquot_q;
  logic [10:0] mrem_q;
  logic        mneg_q;
  logic [47:0] sn_q, sqt_q;
  logic [10:0] sr_q;

  logic [41:0] trial;
  logic [58:0] dshift;
  logic [11:0] mshift;
  logic [11:0] sshift;
  logic [38:0] qsat;
  logic signed [41:0] csum;
  logic [48:0] ssum;
  logic [39:0] chi_abs;
  logic [39:0] mean_abs;
  logic        mean_load;

  assign trial   = {rem_q, rad_q[39:38]} - {20'd0, root_q, 2'b01};
  assign dshift  = {drem_q, num_q[57]};
  assign mshift  = {mrem_q, mnum_q[47]};
  assign sshift  = {sr_q, sn_q[47]};
  assign qsat    = (quot_q > 58'h7FFFFFFFFF) ? 39'h7FFFFFFFFF : quot_q[38:0];
  assign chi_abs = chi_d[39] ? 40'(-chi_d) : chi_d;
  assign mean_abs  = mquot_q[39:0];
  assign mean_load = state_q == StIdle || state_q == StAcc;

  assign job_ready_o = state_q == StIdle;
  assign clear_o     = state_q == StOut && res_ready_i;
  assign res_valid_o = state_q == StOut;

  assign csum = (job_q.neg ? -42'(signed'({3'd0, qsat})) : 42'(signed'({3'd0, qsat})))
                + 42'(chi_q);
  assign ssum = {1'b0, sq_q} + ((quot_q >= 58'h100000000) ? 49'h0FFFFFFFFFFFF
                : {1'b0, prod_q[63:16]});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (job_valid_i) state_d = job_i.do_chi ? StSqrt : (job_i.last ? StMean : StIdle);
      StSqrt: if (step_q == 6'd19) state_d = StMul;
      StMul:  state_d = StDiv;
      StDiv:  if (step_q == 6'd57) state_d = StSq;
      StSq:   state_d = StAcc;
      StAcc:  state_d = job_q.last ? StMean : StIdle;
      StMean: if (step_q == 6'd47) state_d = StOut;
      StOut:  if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    chi_d = chi_q;
    sq_d  = sq_q;
    cnt_d = cnt_q;
    if (state_q == StAcc) begin
      if (csum > 42'sh7FFFFFFFFF) chi_d = 40'sh7FFFFFFFFF;
      else if (csum < -42'sh8000000000) chi_d = 40'sh8000000000;
      else chi_d = csum[39:0];
      sq_d = ssum[48] ? 48'hFFFFFFFFFFFF : ssum[47:0];
      if (cnt_q < Cap) cnt_d = cnt_q + 11'd1;
    end
    if (clear_o) begin
      chi_d = '0;
      sq_d  = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= 6'd0;
      chi_q   <= '0;
      sq_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_d != state_q) ? 6'd0 : step_q + 6'd1;
      chi_q   <= chi_d;
      sq_q    <= sq_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        job_q  <= job_i;
        rad_q  <= {job_i.trk, 16'd0};
        rem_q  <= '0;
        root_q <= '0;
      end
      StSqrt: begin
        rad_q <= {rad_q[37:0], 2'b00};
        if (!trial[41]) begin
          rem_q  <= trial[39:0];
          root_q <= {root_q[18:0], 1'b1};
        end else begin
          rem_q  <= {rem_q[37:0], rad_q[39:38]};
          root_q <= {root_q[18:0], 1'b0};
        end
      end
      StMul: begin
        den_q  <= 36'(resolution_i * root_q);
        num_q  <= {job_q.mag, 34'd0};
        drem_q <= '0;
        quot_q <= '0;
      end
      StDiv: begin
        num_q <= {num_q[56:0], 1'b0};
        if (dshift >= {23'd0, den_q}) begin
          drem_q <= 58'(dshift - {23'd0, den_q});
          quot_q <= {quot_q[56:0], 1'b1};
        end else begin
          drem_q <= dshift[57:0];
          quot_q <= {quot_q[56:0], 1'b0};
        end
      end
      StSq: begin
        prod_q <= 64'(quot_q[31:0]) * 64'(quot_q[31:0]);
      end
      default: begin
      end
    endcase
  end

  // Both means are divided in parallel, loaded from the final sums.
  always_ff @(posedge clk_i) begin
    if (mean_load) begin
      mneg_q  <= chi_d[39];
      mnum_q  <= {8'd0, chi_abs};
      mrem_q  <= '0;
      mquot_q <= '0;
      sn_q    <= sq_d;
      sr_q    <= '0;
      sqt_q   <= '0;
    end else if (state_q == StMean) begin
      mnum_q <= {mnum_q[46:0], 1'b0};
      if (mshift >= {1'b0, cnt_q} && cnt_q != 11'd0) begin
        mrem_q  <= 11'(mshift - {1'b0, cnt_q});
        mquot_q <= {mquot_q[46:0], 1'b1};
      end else begin
        mrem_q  <= mshift[10:0];
        mquot_q <= {mquot_q[46:0], 1'b0};
      end
      sn_q <= {sn_q[46:0], 1'b0};
      if (sshift >= {1'b0, cnt_q} && cnt_q != 11'd0) begin
        sr_q  <= 11'(sshift - {1'b0, cnt_q});
        sqt_q <= {sqt_q[46:0], 1'b1};
      end else begin
        sr_q  <= sshift[10:0];
        sqt_q <= {sqt_q[46:0], 1'b0};
      end
    end
  end

  always_comb begin
    res_o = '0;
    res_o.unassociated_energy   = unassoc_i;
    res_o.min_associated_energy = min_i;
    res_o.excess_tracks         = excess_i;
    if (error_i) res_o.status = tcca_pkg::StatusError;
    else if (cnt_q == 11'd0) res_o.status = tcca_pkg::StatusNoAssoc;
    else begin
      res_o.status            = tcca_pkg::StatusOk;
      res_o.chi_total         = chi_q;
      res_o.chi_squared_total = sq_q;
      res_o.chi_mean          = mneg_q ? -$signed(mean_abs) : $signed(mean_abs);
      res_o.chi_squared_mean  = sqt_q;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> res_valid_o) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> !job_ready_o) else $error("accepted job while dividing");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Cap)
    else $error("count above cap");

endmodule

`default_nettype wire

>>> rtl/core/track_cluster_chi_accumulator.sv
// ----------------------------------------------------------------------------
// Track cluster chi accumulator
// Scores cluster energies against their track energies per candidate list.
// ----------------------------------------------------------------------------
// An associated cluster holds the back part while it takes the job and runs
// 20 square root steps, one multiply, 58 divide steps, one square, one accumulate.
// Other clusters skip these steps in the back part; a two-entry queue decouples the front.
// A last cluster adds 48 mean steps before the result beat, and input stalls
// from its acceptance until that beat is taken.
// Reset clears all sums, sets the minimum to all ones and resolution to 9830.
`default_nettype none

module track_cluster_chi_accumulator #(
  parameter int unsigned MAX_CLUSTERS = 1024
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tcca_in_if.sink   in_i,
  tcca_out_if.source out_o,
  tcca_cfg_if.sink  cfg_i
);

  logic [15:0] res_q;
  tcca_pkg::in_item_t item;
  tcca_pkg::job_t fjob, bjob;
  tcca_pkg::out_item_t res;
  logic fvalid, fready, bvalid, bready, clear;
  logic [31:0] unassoc;
  logic [23:0] minv;
  logic [15:0] excess;
  logic err;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_q <= tcca_pkg::ResolutionReset;
    else if (cfg_i.valid) res_q <= cfg_i.data;
  end

  assign item.cluster_hadronic_energy   = in_i.cluster_hadronic_energy;
  assign item.cluster_comparison_energy = in_i.cluster_comparison_energy;
  assign item.track_count               = in_i.track_count;
  assign item.track_energy_sum          = in_i.track_energy_sum;
  assign item.last_cluster              = in_i.last_cluster;

  tcca_front u_front (
    .clk_i, .rst_ni, .item_i(item), .item_valid_i(in_i.valid), .item_ready_o(in_i.ready),
    .resolution_i(res_q), .job_o(fjob), .job_valid_o(fvalid), .job_ready_i(fready),
    .unassoc_o(unassoc), .min_o(minv), .excess_o(excess), .error_o(err), .clear_i(clear)
  );

  tcca_queue u_queue (
    .clk_i, .rst_ni, .push_data_i(fjob), .push_valid_i(fvalid), .push_ready_o(fready),
    .pop_data_o(bjob), .pop_valid_o(bvalid), .pop_ready_i(bready)
  );

  tcca_back #(.CountCap(MAX_CLUSTERS)) u_back (
    .clk_i, .rst_ni, .job_i(bjob), .job_valid_i(bvalid), .job_ready_o(bready),
    .resolution_i(res_q), .unassoc_i(unassoc), .min_i(minv), .excess_i(excess),
    .error_i(err), .clear_o(clear), .res_o(res), .res_valid_o(out_o.valid),
    .res_ready_i(out_o.ready)
  );

  assign out_o.status                = res.status;
  assign out_o.chi_total             = res.chi_total;
  assign out_o.chi_squared_total     = res.chi_squared_total;
  assign out_o.chi_mean              = res.chi_mean;
  assign out_o.chi_squared_mean      = res.chi_squared_mean;
  assign out_o.unassociated_energy   = res.unassociated_energy;
  assign out_o.min_associated_energy = res.min_associated_energy;
  assign out_o.excess_tracks         = res.excess_tracks;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Track cluster chi accumulator testbench
// Sends lists of clusters into the block and checks every result beat
// against an internal prediction of the chi sums. Directed lists cover the
// field extremes, the error and no-association cases, the saturation of
// every sum and of the cluster count, and several resolution settings.
// Random lists then run under different sender and receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CountCap = 1024;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 200;
  localparam longint signed ChiMax = 64'sd549755813887;
  localparam longint signed ChiMin = -64'sd549755813888;
  localparam longint unsigned SqMax = 64'hFFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tcca_in_if in_if ();
  tcca_out_if out_if ();
  tcca_cfg_if cfg_if ();

  track_cluster_chi_accumulator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  logic [15:0] resolution = tcca_pkg::ResolutionReset;
  longint signed chi_sum = 0;
  longint unsigned chi_sq_sum = 0;
  int unsigned assoc_clusters = 0;
  longint unsigned unassoc_sum = 0;
  logic [23:0] min_assoc = 24'hFFFFFF;
  int unsigned excess_sum = 0;
  bit list_error = 1'b0;

  tcca_pkg::out_item_t pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_list();
    chi_sum = 0;
    chi_sq_sum = 0;
    assoc_clusters = 0;
    unassoc_sum = 0;
    min_assoc = 24'hFFFFFF;
    excess_sum = 0;
    list_error = 1'b0;
  endfunction

  function automatic void absorb_cluster(tcca_pkg::in_item_t c);
    longint unsigned s, mag, q, sq;
    longint signed chi, total;
    tcca_pkg::out_item_t r;
    if (c.track_count == 0) begin
      unassoc_sum += c.cluster_hadronic_energy;
      if (unassoc_sum > 64'hFFFF_FFFF) unassoc_sum = 64'hFFFF_FFFF;
    end else begin
      if (c.cluster_hadronic_energy < min_assoc) min_assoc = c.cluster_hadronic_energy;
      excess_sum += c.track_count - 1;
      if (excess_sum > 16'hFFFF) excess_sum = 16'hFFFF;
      if (c.track_energy_sum == 0 || resolution == 0) begin
        list_error = 1'b1;
      end else begin
        s = root_floor(64'(c.track_energy_sum) << 16);
        if (c.cluster_comparison_energy < c.track_energy_sum)
          mag = c.track_energy_sum - c.cluster_comparison_energy;
        else
          mag = c.cluster_comparison_energy - c.track_energy_sum;
        q = (mag << 34) / (64'(resolution) * s);
        if (q > 64'(ChiMax)) q = 64'(ChiMax);
        sq = (q >= 64'd1 << 32) ? SqMax : (q * q) >> 16;
        chi = (c.cluster_comparison_energy < c.track_energy_sum) ? -longint'(q)
                                                                  : longint'(q);
        total = chi_sum + chi;
        if (total > ChiMax) total = ChiMax;
        if (total < ChiMin) total = ChiMin;
        chi_sum = total;
        chi_sq_sum += sq;
        if (chi_sq_sum > SqMax) chi_sq_sum = SqMax;
        if (assoc_clusters < CountCap) assoc_clusters++;
      end
    end
    if (c.last_cluster) begin
      r = '0;
      if (list_error) r.status = tcca_pkg::StatusError;
      else if (assoc_clusters == 0) r.status = tcca_pkg::StatusNoAssoc;
      else r.status = tcca_pkg::StatusOk;
      if (r.status == tcca_pkg::StatusOk) begin
        r.chi_total = chi_sum[39:0];
        r.chi_squared_total = chi_sq_sum[47:0];
        r.chi_mean = 40'(chi_sum / longint'(assoc_clusters));
        r.chi_squared_mean = 48'(chi_sq_sum / assoc_clusters);
      end
      r.unassociated_energy = unassoc_sum[31:0];
      r.min_associated_energy = min_assoc;
      r.excess_tracks = excess_sum[15:0];
      pending_results.push_back(r);
      clear_list();
    end
  endfunction

  task automatic send_cluster(tcca_pkg::in_item_t c);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < send_idle_pct) in_if.valid = 1'b0;
      else break;
    end
    in_if.valid = 1'b1;
    in_if.cluster_hadronic_energy = c.cluster_hadronic_energy;
    in_if.cluster_comparison_energy = c.cluster_comparison_energy;
    in_if.track_count = c.track_count;
    in_if.track_energy_sum = c.track_energy_sum;
    in_if.last_cluster = c.last_cluster;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_cluster(c);
  endtask

  function automatic tcca_pkg::in_item_t make_cluster(logic [23:0] had, logic [23:0] cmp,
                                                      logic [7:0] ntr, logic [23:0] trk,
                                                      logic last);
    tcca_pkg::in_item_t c;
    c.cluster_hadronic_energy = had;
    c.cluster_comparison_energy = cmp;
    c.track_count = ntr;
    c.track_energy_sum = trk;
    c.last_cluster = last;
    return c;
  endfunction

  task automatic write_resolution(logic [15:0] value);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    resolution = value;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic test_directed_lists();
    send_cluster(make_cluster(24'd1000, 24'd5000, 8'd1, 24'd5000, 1'b1));
    send_cluster(make_cluster(24'hFFFFFF, 24'hFFFFFF, 8'd255, 24'hFFFFFF, 1'b0));
    send_cluster(make_cluster(24'd0, 24'd0, 8'd1, 24'hFFFFFF, 1'b0));
    send_cluster(make_cluster(24'd300, 24'hFFFFFF, 8'd2, 24'd1, 1'b0));
    send_cluster(make_cluster(24'hFFFFFF, 24'd7, 8'd0, 24'd9, 1'b1));
    send_cluster(make_cluster(24'd55, 24'd1, 8'd0, 24'd0, 1'b1));
    send_cluster(make_cluster(24'd70, 24'd80, 8'd3, 24'd0, 1'b0));
    send_cluster(make_cluster(24'd90, 24'd900, 8'd1, 24'd1000, 1'b1));
    send_cluster(make_cluster(24'd10, 24'd20, 8'd4, 24'd0, 1'b1));
    send_cluster(make_cluster(24'd0, 24'd0, 8'd0, 24'd0, 1'b1));
  endtask

  task automatic test_resolution_extremes();
    write_resolution(16'd0);
    send_cluster(make_cluster(24'd500, 24'd600, 8'd1, 24'd700, 1'b0));
    send_cluster(make_cluster(24'd20, 24'd0, 8'd0, 24'd0, 1'b1));
    write_resolution(16'hFFFF);
    send_cluster(make_cluster(24'd500, 24'hFFFFFF, 8'd1, 24'd1, 1'b0));
    send_cluster(make_cluster(24'd400, 24'd0, 8'd2, 24'hFFFFFF, 1'b1));
    write_resolution(16'd1);
    send_cluster(make_cluster(24'd500, 24'hFFFFFF, 8'd1, 24'd1, 1'b0));
    send_cluster(make_cluster(24'd500, 24'd0, 8'd1, 24'hFFFFFF, 1'b1));
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 1026; i++)
      send_cluster(make_cluster(24'($urandom), 24'hFFFFFF, 8'd255, 24'd1, i == 1025));
    for (int i = 0; i < 258; i++)
      send_cluster(make_cluster(24'hFFFFFF, 24'($urandom), 8'd0, 24'($urandom),
                                i == 257));
  endtask

  function automatic tcca_pkg::in_item_t random_cluster(logic last);
    tcca_pkg::in_item_t c;
    c = tcca_pkg::in_item_t'(81'({$urandom, $urandom, $urandom}));
    c.last_cluster = last;
    case ($urandom_range(9))
      0, 1, 2: c.track_count = 8'd0;
      3, 4, 5: c.track_count = 8'($urandom_range(1, 3));
      default: ;
    endcase
    case ($urandom_range(9))
      0: c.track_energy_sum = 24'd0;
      1, 2: c.track_energy_sum = 24'($urandom_range(1, 255));
      3, 4, 5:
        c.cluster_comparison_energy = c.track_energy_sum ^ 24'($urandom_range(4095));
      default: ;
    endcase
    return c;
  endfunction

  task automatic test_random_phase(int unsigned send_pct, int unsigned stall_pct,
                                   logic [15:0] res_value, bit hold_off);
    int unsigned sent;
    int unsigned len;
    write_resolution(res_value);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    if (hold_off) hold_cycles = 3000;
    sent = 0;
    while (sent < 25) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) send_cluster(random_cluster(i == len - 1));
      sent += len;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_if.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s expected %0h actual %0h", name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    tcca_pkg::out_item_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no result pending");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_if.status);
        check_field("chi_total", e.chi_total, out_if.chi_total);
        check_field("chi_squared_total", e.chi_squared_total, out_if.chi_squared_total);
        check_field("chi_mean", e.chi_mean, out_if.chi_mean);
        check_field("chi_squared_mean", e.chi_squared_mean, out_if.chi_squared_mean);
        check_field("unassociated_energy", e.unassociated_energy,
                    out_if.unassociated_energy);
        check_field("min_associated_energy", e.min_associated_energy,
                    out_if.min_associated_energy);
        check_field("excess_tracks", e.excess_tracks, out_if.excess_tracks);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.cluster_hadronic_energy = '0;
    in_if.cluster_comparison_energy = '0;
    in_if.track_count = '0;
    in_if.track_energy_sum = '0;
    in_if.last_cluster = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_lists();
    test_resolution_extremes();
    test_saturation();
    test_random_phase(0, 0, tcca_pkg::ResolutionReset, 1'b0);
    test_random_phase(53, 0, 16'($urandom_range(1, 65535)), 1'b0);
    test_random_phase(0, 53, 16'($urandom_range(1, 400)), 1'b1);
    test_random_phase(20, 20, 16'($urandom_range(8000, 20000)), 1'b0);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
